FILE: rtl/tpfc_pkg.sv
package tpfc_pkg;

    // Fixed field widths of the sample and point transactions.
    localparam int SAMPLE_BITS = 12;
    localparam int COORD_BITS  = 10;
    localparam int GAIN_BITS   = 32;
    localparam int OFFSET_BITS = 16;
    localparam int FRAC_BITS   = 24;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = GAIN_BITS;

    localparam logic [COORD_BITS-1:0] COORD_MAX = 10'd1023;
    localparam logic [COORD_BITS-1:0] X_REFERENCE_RESET = 10'd240;
    localparam logic [COORD_BITS-1:0] Y_REFERENCE_RESET = 10'd320;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_X_GAIN      = 3'd0,
        CFG_Y_GAIN      = 3'd1,
        CFG_X_OFFSET    = 3'd2,
        CFG_Y_OFFSET    = 3'd3,
        CFG_X_REFERENCE = 3'd4,
        CFG_Y_REFERENCE = 3'd5
    } cfg_index_t;

    // Axis tag carried by each job between the front and the back.
    typedef enum logic {
        AXIS_X = 1'b0,
        AXIS_Y = 1'b1
    } axis_t;

    typedef struct packed {
        logic                   pen_down;
        logic [SAMPLE_BITS-1:0] raw_sample;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x_coord;
        logic [COORD_BITS-1:0] y_coord;
    } out_item_t;

    // Calibration settings handed to the back end.
    typedef struct packed {
        logic signed [GAIN_BITS-1:0] x_gain;
        logic signed [GAIN_BITS-1:0] y_gain;
        logic [OFFSET_BITS-1:0]      x_offset;
        logic [OFFSET_BITS-1:0]      y_offset;
        logic [COORD_BITS-1:0]       x_reference;
        logic [COORD_BITS-1:0]       y_reference;
    } cal_cfg_t;

endpackage

FILE: rtl/tpfc_front.sv
module tpfc_front
    import tpfc_pkg::*;
#(
    parameter int SAMPLES_PER_AXIS = 5,
    parameter int SUM_BITS = SAMPLE_BITS + $clog2(SAMPLES_PER_AXIS)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_data,
    input  logic                queue_full,
    output logic                push,
    output axis_t               push_axis,
    output logic [SUM_BITS-1:0] push_tsum
);

    localparam int CW = $clog2(2 * SAMPLES_PER_AXIS);
    localparam logic [CW-1:0] LAST_X  = CW'(SAMPLES_PER_AXIS - 1);
    localparam logic [CW-1:0] FIRST_Y = CW'(SAMPLES_PER_AXIS);
    localparam logic [CW-1:0] LAST_Y  = CW'(2 * SAMPLES_PER_AXIS - 1);

    logic                   latched_reg, latched_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic                   accept;
    logic                   take;
    logic                   axis_start;

    // The front only holds off when the job queue cannot take another entry.
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign take     = accept && in_data.pen_down && !latched_reg;
    assign axis_start = (count_reg == '0) || (count_reg == FIRST_Y);

    // Running sum, minimum and maximum of the axis being collected.
    always_comb
    begin
        if (axis_start)
        begin
            sum_next = SUM_BITS'(in_data.raw_sample);
            min_next = in_data.raw_sample;
            max_next = in_data.raw_sample;
        end
        else
        begin
            sum_next = sum_reg + SUM_BITS'(in_data.raw_sample);
            min_next = (in_data.raw_sample < min_reg) ? in_data.raw_sample : min_reg;
            max_next = (in_data.raw_sample > max_reg) ? in_data.raw_sample : max_reg;
        end
    end

    // Touch sequencing: pen up clears, a latched touch ignores samples.
    always_comb
    begin
        latched_next = latched_reg;
        count_next   = count_reg;
        if (accept && !in_data.pen_down)
        begin
            latched_next = 1'b0;
            count_next   = '0;
        end
        else if (take)
        begin
            if (count_reg == LAST_Y)
            begin
                latched_next = 1'b1;
                count_next   = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // A finished axis leaves as a job with the trimmed sum.
    assign push      = take && ((count_reg == LAST_X) || (count_reg == LAST_Y));
    assign push_axis = (count_reg == LAST_Y) ? AXIS_Y : AXIS_X;
    assign push_tsum = sum_next - SUM_BITS'(min_next) - SUM_BITS'(max_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            latched_reg <= latched_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sum_reg <= sum_next;
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

endmodule

FILE: rtl/tpfc_queue.sv
module tpfc_queue
    import tpfc_pkg::*;
#(
    parameter int SUM_BITS = 15
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  axis_t               push_axis,
    input  logic [SUM_BITS-1:0] push_tsum,
    input  logic                pop,
    output logic                empty,
    output logic                full,
    output axis_t               head_axis,
    output logic [SUM_BITS-1:0] head_tsum
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [SUM_BITS:0] entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]       fill_reg, fill_next;
    logic              do_push, do_pop;

    assign empty   = (fill_reg == '0);
    assign full    = (fill_reg == (PW+1)'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign head_axis = axis_t'(entry_reg[rd_ptr_reg][SUM_BITS]);
    assign head_tsum = entry_reg[rd_ptr_reg][SUM_BITS-1:0];

    // Fill level follows pushes and pops.
    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= {push_axis, push_tsum};
        end
    end

endmodule

FILE: rtl/tpfc_back.sv
module tpfc_back
    import tpfc_pkg::*;
#(
    parameter int SAMPLES_PER_AXIS = 5,
    parameter int SUM_BITS = SAMPLE_BITS + $clog2(SAMPLES_PER_AXIS)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cal_cfg_t            cal_cfg,
    input  logic                job_empty,
    input  axis_t               job_axis,
    input  logic [SUM_BITS-1:0] job_tsum,
    output logic                job_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_data
);

    // Division by the number of kept samples through a reciprocal.
    localparam int DIV   = SAMPLES_PER_AXIS - 2;
    localparam int K     = SUM_BITS;
    localparam int MW    = K + 1;
    localparam int PRODW = SUM_BITS + MW;
    localparam int REMW  = SUM_BITS + 4;
    localparam logic [MW-1:0] RECIP = MW'((2 ** K) / DIV);
    localparam int MULW  = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int VW    = SAMPLE_BITS + 35;

    logic                   advance;

    logic                   s1_valid_reg;
    axis_t                  s1_axis_reg;
    logic [SUM_BITS-1:0]    s1_tsum_reg;
    logic [PRODW-1:0]       s1_prod_reg;

    logic                   s2_valid_reg;
    axis_t                  s2_axis_reg;
    logic [SAMPLE_BITS-1:0] s2_avg_reg;

    logic                   s3_valid_reg;
    axis_t                  s3_axis_reg;
    logic signed [MULW-1:0] s3_mul_reg;

    logic [COORD_BITS-1:0]  held_x_reg;
    logic                   out_valid_reg;
    out_item_t              out_data_reg;

    logic [SUM_BITS-1:0]    quot_est;
    logic [REMW-1:0]        rem;
    logic [SUM_BITS-1:0]    avg_next;
    logic signed [GAIN_BITS-1:0] gain_sel;
    logic signed [MULW-1:0] mul_next;
    logic signed [VW-1:0]   ref_term, off_term, cal_value;
    logic [VW-FRAC_BITS-1:0] cal_int;
    logic [COORD_BITS-1:0]  coord_next;

    // The whole back pipeline moves unless a point waits at the output.
    assign advance = !(out_valid_reg && out_stall);
    assign job_pop = advance && !job_empty;

    // Stage two: fix the reciprocal estimate, which is at most one low.
    assign quot_est = s1_prod_reg[K +: SUM_BITS];
    assign rem      = REMW'(s1_tsum_reg) - REMW'(quot_est) * REMW'(DIV);
    assign avg_next = (rem >= REMW'(DIV)) ? quot_est + 1'b1 : quot_est;

    // Stage three: scale the average by the gain of its axis.
    assign gain_sel = (s2_axis_reg == AXIS_Y) ? cal_cfg.y_gain : cal_cfg.x_gain;
    assign mul_next = $signed({1'b0, s2_avg_reg}) * gain_sel;

    // Last stage: reference minus (scaled average minus offset), then saturate.
    always_comb
    begin
        if (s3_axis_reg == AXIS_Y)
        begin
            ref_term = VW'({cal_cfg.y_reference, {FRAC_BITS{1'b0}}});
            off_term = VW'({cal_cfg.y_offset, {FRAC_BITS{1'b0}}});
        end
        else
        begin
            ref_term = VW'({cal_cfg.x_reference, {FRAC_BITS{1'b0}}});
            off_term = VW'({cal_cfg.x_offset, {FRAC_BITS{1'b0}}});
        end
        cal_value = ref_term - VW'(s3_mul_reg) + off_term;
        cal_int   = cal_value[VW-1:FRAC_BITS];
        if (cal_value <= 0)
        begin
            coord_next = '0;
        end
        else if (cal_int > (VW-FRAC_BITS)'(COORD_MAX))
        begin
            coord_next = COORD_MAX;
        end
        else
        begin
            coord_next = cal_int[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_x_reg    <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= job_pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg && (s3_axis_reg == AXIS_Y);
            if (s3_valid_reg && (s3_axis_reg == AXIS_X))
            begin
                held_x_reg <= coord_next;
            end
        end
    end

    // Payload registers of the stages.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_axis_reg <= job_axis;
            s1_tsum_reg <= job_tsum;
            s1_prod_reg <= PRODW'(job_tsum) * PRODW'(RECIP);
            s2_axis_reg <= s1_axis_reg;
            s2_avg_reg  <= avg_next[SAMPLE_BITS-1:0];
            s3_axis_reg <= s2_axis_reg;
            s3_mul_reg  <= mul_next;
            if (s3_valid_reg && (s3_axis_reg == AXIS_Y))
            begin
                out_data_reg.x_coord <= held_x_reg;
                out_data_reg.y_coord <= coord_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/touch_point_filter_calibrate.sv
// Touch point filter and calibrator. Raw converter samples arrive one per
// transaction with the pen level; a pen-down touch collects SAMPLES_PER_AXIS X
// samples, then as many Y samples, keeps a trimmed mean of each axis and turns
// it into a calibrated, saturated 10-bit screen coordinate. One point leaves
// per touch; the touch stays latched until a pen-up sample arrives. The block
// takes one sample per clock cycle while in_stall is low. The front end tracks
// the running sum, minimum and maximum as samples come in, so a finished axis
// is handed to a four-entry job queue in the same cycle; the back end is a
// four-stage pipeline (reciprocal divide, correction, gain multiply, offset
// and saturation). in_stall rises only when four axis jobs wait because
// out_stall holds the back end. Calibration registers must be written
// through cfg_write_enable only while no touch is in progress; the block
// itself does not enforce this.
module touch_point_filter_calibrate
    import tpfc_pkg::*;
#(
    parameter int SAMPLES_PER_AXIS = 5
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_enable,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_item_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_item_t                 out_data
);

    localparam int SUM_BITS = SAMPLE_BITS + $clog2(SAMPLES_PER_AXIS);

    cal_cfg_t            cal_cfg_reg;
    logic                queue_full;
    logic                queue_empty;
    logic                push;
    axis_t               push_axis;
    logic [SUM_BITS-1:0] push_tsum;
    logic                pop;
    axis_t               head_axis;
    logic [SUM_BITS-1:0] head_tsum;

    // Calibration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_cfg_reg.x_gain      <= '0;
            cal_cfg_reg.y_gain      <= '0;
            cal_cfg_reg.x_offset    <= '0;
            cal_cfg_reg.y_offset    <= '0;
            cal_cfg_reg.x_reference <= X_REFERENCE_RESET;
            cal_cfg_reg.y_reference <= Y_REFERENCE_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_X_GAIN:      cal_cfg_reg.x_gain      <= $signed(cfg_data);
                CFG_Y_GAIN:      cal_cfg_reg.y_gain      <= $signed(cfg_data);
                CFG_X_OFFSET:    cal_cfg_reg.x_offset    <= cfg_data[OFFSET_BITS-1:0];
                CFG_Y_OFFSET:    cal_cfg_reg.y_offset    <= cfg_data[OFFSET_BITS-1:0];
                CFG_X_REFERENCE: cal_cfg_reg.x_reference <= cfg_data[COORD_BITS-1:0];
                CFG_Y_REFERENCE: cal_cfg_reg.y_reference <= cfg_data[COORD_BITS-1:0];
                default:         ;
            endcase
        end
    end

    tpfc_front #(
        .SAMPLES_PER_AXIS(SAMPLES_PER_AXIS),
        .SUM_BITS        (SUM_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .queue_full(queue_full),
        .push      (push),
        .push_axis (push_axis),
        .push_tsum (push_tsum)
    );

    tpfc_queue #(
        .SUM_BITS(SUM_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_axis(push_axis),
        .push_tsum(push_tsum),
        .pop      (pop),
        .empty    (queue_empty),
        .full     (queue_full),
        .head_axis(head_axis),
        .head_tsum(head_tsum)
    );

    tpfc_back #(
        .SAMPLES_PER_AXIS(SAMPLES_PER_AXIS),
        .SUM_BITS        (SUM_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cal_cfg  (cal_cfg_reg),
        .job_empty(queue_empty),
        .job_axis (head_axis),
        .job_tsum (head_tsum),
        .job_pop  (pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

endmodule

FILE: rtl/tpfc_checker.sv
module tpfc_checker
    import tpfc_pkg::*;
#(
    parameter int SAMPLES_PER_AXIS = 5
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data
);

    localparam int NEED = 2 * SAMPLES_PER_AXIS;
    localparam int NW   = $clog2(NEED + 1);

    logic [NW-1:0] seen_reg;
    logic          pen_sample;

    assign pen_sample = in_valid && !in_stall && in_data.pen_down;

    // Pen-down samples accepted since reset, saturating at one full touch.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (pen_sample && (seen_reg != NW'(NEED)))
        begin
            seen_reg <= seen_reg + 1'b1;
        end
    end

    // A stalled point transaction keeps its coordinates.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("point changed while stalled");

    // No point can leave before a whole touch worth of samples came in.
    a_out_needs_touch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_reg == NW'(NEED))
        else $error("point without a full set of samples");

    // The input only backs up after it took a pen-down sample.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(pen_sample))
        else $error("input stall without a queued axis job");

    // Backpressure on the input needs a stalled output behind it.
    a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall while the output drains");

endmodule

bind touch_point_filter_calibrate tpfc_checker #(
    .SAMPLES_PER_AXIS(SAMPLES_PER_AXIS)
) u_tpfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
);
